// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// check prop on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
// check prop on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/efr_pkg.sv =====
// ----------------------------------------------------------------------------
// efr_pkg
// types, constants and the crc step for the encoder frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package efr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned POS_W   = 21;

    localparam logic [BYTE_W-1:0] CONTROL_RESET = 8'h02;
    localparam logic [BYTE_W-1:0] CRC_POLY      = 8'h01;

    localparam int unsigned COUNT_BIT  = 4;
    localparam int unsigned MTBATT_BIT = 5;

    // byte positions inside a frame
    localparam logic [IDX_W-1:0] IDX_CONTROL = 3'd0;
    localparam logic [IDX_W-1:0] IDX_STATUS  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_POS0    = 3'd2;
    localparam logic [IDX_W-1:0] IDX_POS1    = 3'd3;
    localparam logic [IDX_W-1:0] IDX_POS2    = 3'd4;
    localparam logic [IDX_W-1:0] IDX_CRC     = 3'd5;
    localparam logic [IDX_W-1:0] FRAME_BYTES = 3'd6;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_CONTROL = 2'd1,
        ST_CRC_ERROR   = 2'd2
    } t_frame_status;

    // one byte of crc8, msb first
    function automatic logic [BYTE_W-1:0] crc_byte(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/encoder_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// encoder_frame_receiver
// six-byte absolute encoder reply receiver with control and crc8 check
// ----------------------------------------------------------------------------
// throughput: one byte beat per cycle, bar a stalled crc byte; the input register feeds
//   the frame logic and a result register, so other bytes flow while a result waits
// the result beat is valid in the cycle after the crc byte is accepted
// a held result stalls the crc byte of the next frame and the input behind it
// reset (i_rst_n low, synchronous): byte counter and checks cleared,
//   no beats pending, expected control value back to 0x02
`default_nettype none

`include "assert_macros.svh"

module encoder_frame_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,     // expected_control
    // byte stream in
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    input  wire logic        s_axis_tuser,    // [0] frame_start
    // result stream out
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [23:0] m_axis_tdata,    // [0] cnt_err,
                                              // [1] multiturn_batt_error,
                                              // [22:2] abs_position, [23] zero
    output      logic [1:0]  m_axis_tuser     // [1:0] frame_status
);

    localparam int unsigned BW = efr_pkg::BYTE_W;
    localparam int unsigned IW = efr_pkg::IDX_W;
    localparam int unsigned PW = efr_pkg::POS_W;

    logic [BW-1:0] r_expected;

    logic          r_in_valid;
    logic [BW-1:0] r_in_byte;
    logic          r_in_start;

    logic [IW-1:0] r_byte_index, n_byte_index;
    logic [BW-1:0] r_crc_acc,    n_crc_acc;
    logic          r_control_ok, n_control_ok;
    logic [BW-1:0] r_status,     n_status;
    logic [PW-1:0] r_pos_acc,    n_pos_acc;

    logic                   r_out_valid;
    efr_pkg::t_frame_status r_out_status, n_out_status;
    logic                   r_out_cnt,    n_out_cnt;
    logic                   r_out_mt,     n_out_mt;
    logic [PW-1:0]          r_out_pos,    n_out_pos;

    logic [IW-1:0] w_idx;
    logic          w_final;
    logic          w_go;

    // an out-of-range count is taken as the control byte
    assign w_idx   = (r_in_start || (r_byte_index >= efr_pkg::FRAME_BYTES))
                     ? efr_pkg::IDX_CONTROL : r_byte_index;
    assign w_final = (w_idx == efr_pkg::IDX_CRC);
    // only the crc byte needs room in the result register
    assign w_go    = r_in_valid && (!w_final || !r_out_valid || m_axis_tready);

    assign s_axis_tready = !r_in_valid || w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= efr_pkg::CONTROL_RESET;
        end else if (i_cfg_we) begin
            r_expected <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    always_comb begin
        n_byte_index = r_byte_index;
        n_crc_acc    = r_crc_acc;
        n_control_ok = r_control_ok;
        n_status     = r_status;
        n_pos_acc    = r_pos_acc;
        unique case (w_idx)
            efr_pkg::IDX_CONTROL: begin
                n_crc_acc    = efr_pkg::crc_byte('0, r_in_byte);
                n_pos_acc    = '0;
                n_status     = '0;
                n_control_ok = (r_in_byte == r_expected);
                n_byte_index = efr_pkg::IDX_STATUS;
            end
            efr_pkg::IDX_STATUS: begin
                n_crc_acc    = efr_pkg::crc_byte(r_crc_acc, r_in_byte);
                n_status     = r_in_byte;
                n_byte_index = efr_pkg::IDX_POS0;
            end
            efr_pkg::IDX_POS0: begin
                n_crc_acc       = efr_pkg::crc_byte(r_crc_acc, r_in_byte);
                n_pos_acc[7:0]  = r_in_byte;
                n_byte_index    = efr_pkg::IDX_POS1;
            end
            efr_pkg::IDX_POS1: begin
                n_crc_acc       = efr_pkg::crc_byte(r_crc_acc, r_in_byte);
                n_pos_acc[15:8] = r_in_byte;
                n_byte_index    = efr_pkg::IDX_POS2;
            end
            efr_pkg::IDX_POS2: begin
                // top byte: only 5 bits land in the position, all 8 go to the crc
                n_crc_acc        = efr_pkg::crc_byte(r_crc_acc, r_in_byte);
                n_pos_acc[PW-1:16] = r_in_byte[PW-17:0];
                n_byte_index     = efr_pkg::IDX_CRC;
            end
            default: begin
                n_byte_index = efr_pkg::IDX_CONTROL;
            end
        endcase
    end

    always_comb begin
        n_out_status = efr_pkg::ST_OK;
        n_out_cnt    = 1'b0;
        n_out_mt     = 1'b0;
        n_out_pos    = '0;
        if (!r_control_ok) begin
            n_out_status = efr_pkg::ST_BAD_CONTROL;
        end else if (r_crc_acc != r_in_byte) begin
            n_out_status = efr_pkg::ST_CRC_ERROR;
        end else begin
            n_out_cnt = r_status[efr_pkg::COUNT_BIT];
            n_out_mt  = r_status[efr_pkg::MTBATT_BIT];
            n_out_pos = r_pos_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_crc_acc    <= '0;
            r_control_ok <= 1'b0;
            r_status     <= '0;
            r_pos_acc    <= '0;
        end else if (w_go) begin
            r_byte_index <= n_byte_index;
            r_crc_acc    <= n_crc_acc;
            r_control_ok <= n_control_ok;
            r_status     <= n_status;
            r_pos_acc    <= n_pos_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_final) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_final) begin
            r_out_status <= n_out_status;
            r_out_cnt    <= n_out_cnt;
            r_out_mt     <= n_out_mt;
            r_out_pos    <= n_out_pos;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {1'b0, r_out_pos, r_out_mt, r_out_cnt};

    `ASSERT_CLK(a_idx_range, i_clk, i_rst_n, r_byte_index <= efr_pkg::IDX_CRC)
    `ASSERT_CLK(a_wrap_after_crc, i_clk, i_rst_n,
        (w_go && w_final) |=> (r_byte_index == efr_pkg::IDX_CONTROL))
    `ASSERT_CLK(a_crc_byte_waits, i_clk, i_rst_n,
        (r_in_valid && w_final && r_out_valid && !m_axis_tready) |-> !w_go)
    `ASSERT_CLK(a_err_zero_payload, i_clk, i_rst_n,
        (r_out_valid && (r_out_status != efr_pkg::ST_OK)) |->
        (m_axis_tdata == '0))

endmodule

`default_nettype wire
